>>> sv/tsc_pkg.sv
// Package for the two-sided CUSUM detector: widths, reset values, codes and
// the structs passed between the front, the queue, the back end and the divider.
// No dependencies.
package tsc_pkg;

   // default fraction width of the Q format
   localparam int FRAC_BITS_DEF = 16;
   // entries in the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // field widths
   localparam int WORD_W = 32;
   localparam int SUM_W = 31;
   localparam int DIFF_W = 33;
   localparam int DIV_MAG_W = 32;
   localparam int DIV_DEN_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [WORD_W-1:0] COUNT_MAX = '1;

   // register reset values
   localparam logic [WORD_W-1:0] MEAN_REF_RST = 32'd0;
   localparam logic [SUM_W-1:0] PROCESS_SIGMA_RST = 31'd65536;
   localparam logic [SUM_W-1:0] DECISION_LIMIT_RST = 31'd327680;
   localparam logic [WORD_W-1:0] SHIFT_TO_DETECT_RST = 32'd65536;

   // register indexes on the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MEAN_REF = 2'd0,
      REG_PROCESS_SIGMA = 2'd1,
      REG_DECISION_LIMIT = 2'd2,
      REG_SHIFT_TO_DETECT = 2'd3
   } tsc_reg_type;

   // request codes
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   // status codes
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_SIGMA_ZERO = 1'b1;

   // operation decided by the front
   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_CLEAR = 2'd1,
      OP_ERROR = 2'd2
   } tsc_op_type;

   typedef struct packed {
      tsc_op_type op;
      logic signed [DIFF_W-1:0] diff;
   } tsc_entry_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] mean_ref;
      logic [SUM_W-1:0] process_sigma;
      logic [SUM_W-1:0] decision_limit;
      logic signed [WORD_W-1:0] shift_to_detect;
   } tsc_cfg_type;

   typedef struct packed {
      logic start;
      logic signed [DIFF_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } tsc_div_req_type;

   typedef struct packed {
      logic done;
      logic signed [WORD_W-1:0] quot;
   } tsc_div_rsp_type;

   // back-end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_Z_START,
      ST_Z_WAIT,
      ST_K_START,
      ST_K_WAIT,
      ST_SUM,
      ST_ALARM,
      ST_EMIT
   } tsc_state_type;

endpackage

>>> sv/tsc_ifs.sv
// Channel interfaces of the CUSUM detector: request, response and register write.
// Depends on tsc_pkg.
interface tsc_req_if import tsc_pkg::*; ();
   logic valid;
   logic ready;
   logic req_type;
   logic signed [WORD_W-1:0] sample;

   modport source (output valid, req_type, sample, input ready);
   modport sink (input valid, req_type, sample, output ready);
endinterface

interface tsc_rsp_if import tsc_pkg::*; ();
   logic valid;
   logic ready;
   logic [SUM_W-1:0] upper_sum;
   logic [SUM_W-1:0] lower_sum;
   logic upper_alarm;
   logic lower_alarm;
   logic [WORD_W-1:0] sample_count;
   logic status;

   modport source (output valid, upper_sum, lower_sum, upper_alarm, lower_alarm,
      sample_count, status, input ready);
   modport sink (input valid, upper_sum, lower_sum, upper_alarm, lower_alarm,
      sample_count, status, output ready);
   modport monitor (input valid, ready, upper_sum, lower_sum, upper_alarm,
      lower_alarm, sample_count, status);
endinterface

interface tsc_csr_if import tsc_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [WORD_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

>>> sv/tsc_div.sv
// Bit-serial restoring divider: signed numerator scaled by 2^FRAC_BITS over an
// unsigned denominator, truncated toward zero and saturated to 32 bits.
// Depends on tsc_pkg.
module tsc_div import tsc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  tsc_div_req_type div_req,
   output tsc_div_rsp_type div_rsp
);

   localparam int DIV_W = DIV_MAG_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_MAG_W:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic neg_ff, neg_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;

   logic [DIV_MAG_W-1:0] mag;
   logic [DIV_MAG_W:0] rem_shift;
   logic rem_ge;
   logic quo_high;

   // magnitude of the numerator and one restoring step
   always_comb begin
      mag = DIV_MAG_W'(div_req.num[DIFF_W-1] ? -div_req.num : div_req.num);
      rem_shift = {rem_ff[DIV_MAG_W-1:0], quo_ff[DIV_W-1]};
      rem_ge = rem_shift >= {1'b0, den_ff};
   end

   // load on start, shift one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      den_in = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(DIV_W);
         rem_in = '0;
         quo_in = {mag, FRAC_BITS'(0)};
         neg_in = div_req.num[DIFF_W-1];
         den_in = div_req.den;
      end else if (busy_ff) begin
         rem_in = rem_ge ? rem_shift - {1'b0, den_ff} : rem_shift;
         quo_in = {quo_ff[DIV_W-2:0], rem_ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
   end

   // saturate the signed quotient
   always_comb begin
      quo_high = |quo_ff[DIV_W-1:WORD_W-1];
      div_rsp.done = done_ff;
      if (neg_ff) begin
         div_rsp.quot = quo_high ? $signed({1'b1, {(WORD_W-1){1'b0}}})
                                 : -$signed({1'b0, quo_ff[WORD_W-2:0]});
      end else begin
         div_rsp.quot = quo_high ? $signed({1'b0, {(WORD_W-1){1'b1}}})
                                 : $signed({1'b0, quo_ff[WORD_W-2:0]});
      end
   end

endmodule

>>> sv/tsc_front.sv
// Front of the CUSUM detector: accepts request words, classifies them and
// forms the centered sample, then offers them to the queue.
// Depends on tsc_pkg and tsc_ifs.
module tsc_front import tsc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   tsc_req_if.sink       req_chan,
   input  tsc_cfg_type   cfg,
   input  logic          queue_full,
   output logic          push,
   output tsc_entry_type push_entry
);

   logic front_valid_ff, front_valid_in;
   tsc_entry_type entry_ff, entry_in;
   logic accept;

   assign req_chan.ready = !front_valid_ff || !queue_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign push = front_valid_ff && !queue_full;
   assign push_entry = entry_ff;

   // classify and center the sample
   always_comb begin
      if (req_chan.req_type == REQ_CLEAR) begin
         entry_in.op = OP_CLEAR;
      end else if (cfg.process_sigma == '0) begin
         entry_in.op = OP_ERROR;
      end else begin
         entry_in.op = OP_SAMPLE;
      end
      entry_in.diff = DIFF_W'(req_chan.sample) - DIFF_W'(cfg.mean_ref);
   end

   // hold the word until the queue takes it
   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

>>> sv/tsc_fifo.sv
// Short queue of classified words between the front and the back end.
// Depends on tsc_pkg.
module tsc_fifo import tsc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  tsc_entry_type push_entry,
   input  logic          pop,
   output tsc_entry_type head,
   output logic          not_empty,
   output logic          full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsc_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign not_empty = cnt_ff != '0;
   assign full = cnt_ff == CNT_W'(DEPTH);
   assign head = slot_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/tsc_back.sv
// Back end of the CUSUM detector: sequences the two divisions, updates the
// sums, alarms and counter, and drives the response register.
// Depends on tsc_pkg, tsc_ifs and tsc_div.
module tsc_back import tsc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  tsc_cfg_type   cfg,
   input  tsc_entry_type head,
   input  logic          not_empty,
   output logic          pop,
   tsc_rsp_if.source     rsp_chan
);

   localparam int ACC_W = WORD_W + 2;
   localparam logic signed [WORD_W-1:0] K_HALF = WORD_W'(1) << (FRAC_BITS - 1);

   tsc_state_type state_ff, state_in;

   logic signed [DIFF_W-1:0] diff_ff;
   logic status_ff;
   logic signed [WORD_W-1:0] z_ff;
   logic signed [WORD_W-1:0] k_ff;
   logic [SUM_W-1:0] upper_ff, upper_in;
   logic [SUM_W-1:0] lower_ff, lower_in;
   logic upper_alarm_ff, lower_alarm_ff;
   logic [WORD_W-1:0] count_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_upper_ff, rsp_lower_ff;
   logic rsp_upper_alarm_ff, rsp_lower_alarm_ff;
   logic [WORD_W-1:0] rsp_count_ff;
   logic rsp_status_ff;

   tsc_div_req_type div_req;
   tsc_div_rsp_type div_rsp;

   logic load_entry, clear_state, cap_z, cap_k, upd_sum, upd_alarm, emit;
   logic out_free;
   logic signed [ACC_W-1:0] acc_up, acc_lo;

   tsc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               unique case (head.op)
                  OP_SAMPLE: state_in = ST_Z_START;
                  OP_CLEAR,
                  OP_ERROR: state_in = ST_EMIT;
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_Z_START: state_in = ST_Z_WAIT;
         ST_Z_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_K_START;
            end
         end
         ST_K_START: state_in = ST_K_WAIT;
         ST_K_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: state_in = ST_ALARM;
         ST_ALARM: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      pop = 1'b0;
      load_entry = 1'b0;
      clear_state = 1'b0;
      cap_z = 1'b0;
      cap_k = 1'b0;
      upd_sum = 1'b0;
      upd_alarm = 1'b0;
      emit = 1'b0;
      div_req.start = 1'b0;
      div_req.num = diff_ff;
      div_req.den = {1'b0, cfg.process_sigma};
      unique case (state_ff)
         ST_IDLE: begin
            pop = not_empty;
            load_entry = not_empty;
            clear_state = not_empty && (head.op == OP_CLEAR);
         end
         ST_Z_START: div_req.start = 1'b1;
         ST_Z_WAIT: cap_z = div_rsp.done;
         ST_K_START: begin
            div_req.start = 1'b1;
            div_req.num = DIFF_W'(cfg.shift_to_detect);
            div_req.den = {cfg.process_sigma, 1'b0};
         end
         ST_K_WAIT: cap_k = div_rsp.done;
         ST_SUM: upd_sum = 1'b1;
         ST_ALARM: upd_alarm = 1'b1;
         ST_EMIT: emit = out_free;
         default: ;
      endcase
   end

   // add, then clamp to the sum range
   always_comb begin
      acc_up = ACC_W'($signed({1'b0, upper_ff})) + ACC_W'(z_ff) - ACC_W'(k_ff);
      acc_lo = ACC_W'($signed({1'b0, lower_ff})) - ACC_W'(z_ff) - ACC_W'(k_ff);
      if (acc_up[ACC_W-1]) begin
         upper_in = '0;
      end else if (acc_up[ACC_W-2:SUM_W] != '0) begin
         upper_in = SUM_MAX;
      end else begin
         upper_in = acc_up[SUM_W-1:0];
      end
      if (acc_lo[ACC_W-1]) begin
         lower_in = '0;
      end else if (acc_lo[ACC_W-2:SUM_W] != '0) begin
         lower_in = SUM_MAX;
      end else begin
         lower_in = acc_lo[SUM_W-1:0];
      end
   end

   // hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         upper_ff <= '0;
         lower_ff <= '0;
         upper_alarm_ff <= 1'b0;
         lower_alarm_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear_state) begin
            upper_ff <= '0;
            lower_ff <= '0;
            upper_alarm_ff <= 1'b0;
            lower_alarm_ff <= 1'b0;
            count_ff <= '0;
         end
         if (upd_sum) begin
            upper_ff <= upper_in;
            lower_ff <= lower_in;
         end
         if (upd_alarm) begin
            upper_alarm_ff <= upper_ff > cfg.decision_limit;
            lower_alarm_ff <= lower_ff > cfg.decision_limit;
            if (count_ff != COUNT_MAX) begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
      if (load_entry) begin
         diff_ff <= head.diff;
         status_ff <= (head.op == OP_ERROR) ? STATUS_SIGMA_ZERO : STATUS_OK;
      end
      if (cap_z) begin
         z_ff <= div_rsp.quot;
      end
      // replace a reference value below one LSB by one half
      if (cap_k) begin
         k_ff <= (div_rsp.quot < WORD_W'(1)) ? K_HALF : div_rsp.quot;
      end
      if (emit) begin
         rsp_upper_ff <= upper_ff;
         rsp_lower_ff <= lower_ff;
         rsp_upper_alarm_ff <= upper_alarm_ff;
         rsp_lower_alarm_ff <= lower_alarm_ff;
         rsp_count_ff <= count_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.upper_sum = rsp_upper_ff;
   assign rsp_chan.lower_sum = rsp_lower_ff;
   assign rsp_chan.upper_alarm = rsp_upper_alarm_ff;
   assign rsp_chan.lower_alarm = rsp_lower_alarm_ff;
   assign rsp_chan.sample_count = rsp_count_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule

>>> sv/two_sided_cusum_detector_core.sv
// Two-sided tabular CUSUM detector. A sample's response waits on the shared bit-serial
// divider, which runs once for z and once for k; a clear or a sigma-zero word skips it.
// The back end works on one word at a time, while the front register and the queue
// let up to QUEUE_DEPTH+1 further words wait.
// Reset clears sums, alarms, counter, queue and handshakes and restores the defaults.
module two_sided_cusum_detector_core import tsc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   tsc_req_if.sink   req_chan,
   tsc_rsp_if.source rsp_chan,
   tsc_csr_if.sink   csr_chan
);

   tsc_cfg_type cfg_ff;
   tsc_entry_type push_entry, head;
   logic push, pop, not_empty, queue_full;

   // registers are always writable
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean_ref <= MEAN_REF_RST;
         cfg_ff.process_sigma <= PROCESS_SIGMA_RST;
         cfg_ff.decision_limit <= DECISION_LIMIT_RST;
         cfg_ff.shift_to_detect <= SHIFT_TO_DETECT_RST;
      end else if (csr_chan.valid) begin
         unique case (tsc_reg_type'(csr_chan.addr))
            REG_MEAN_REF: cfg_ff.mean_ref <= csr_chan.data;
            REG_PROCESS_SIGMA: cfg_ff.process_sigma <= csr_chan.data[SUM_W-1:0];
            REG_DECISION_LIMIT: cfg_ff.decision_limit <= csr_chan.data[SUM_W-1:0];
            REG_SHIFT_TO_DETECT: cfg_ff.shift_to_detect <= csr_chan.data;
            default: ;
         endcase
      end
   end

   tsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   tsc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .full       (queue_full)
   );

   tsc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> sv/tsc_checker.sv
// Port-level checks on the response channel of the CUSUM detector, bound
// to the top level. Depends on tsc_pkg.
module tsc_checker import tsc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [SUM_W-1:0]  rsp_upper_sum,
   input logic [SUM_W-1:0]  rsp_lower_sum,
   input logic              rsp_upper_alarm,
   input logic              rsp_lower_alarm,
   input logic [WORD_W-1:0] rsp_sample_count,
   input logic              rsp_status
);

   // a stalled word keeps its valid
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // a stalled word keeps its payload
   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_upper_sum) && $stable(rsp_lower_sum) &&
         $stable(rsp_upper_alarm) && $stable(rsp_lower_alarm) &&
         $stable(rsp_sample_count) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   // a zero count means nothing accumulated since the last clear
   a_zero_count_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_count == '0 |->
         rsp_upper_sum == '0 && rsp_lower_sum == '0 &&
         !rsp_upper_alarm && !rsp_lower_alarm)
      else $error("nonzero state with zero sample count");

   // an alarm needs a sum above the limit, so never a zero sum
   a_alarm_needs_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (!rsp_upper_alarm || rsp_upper_sum != '0) &&
         (!rsp_lower_alarm || rsp_lower_sum != '0))
      else $error("alarm raised on a zero sum");

endmodule

bind two_sided_cusum_detector_core tsc_checker u_tsc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_upper_sum    (rsp_chan.upper_sum),
   .rsp_lower_sum    (rsp_chan.lower_sum),
   .rsp_upper_alarm  (rsp_chan.upper_alarm),
   .rsp_lower_alarm  (rsp_chan.lower_alarm),
   .rsp_sample_count (rsp_chan.sample_count),
   .rsp_status       (rsp_chan.status)
);

>>> tb/tb.sv
// Self-checking testbench for two_sided_cusum_detector_core: drives request words and
// register writes, predicts every response word and compares it field by field.
// Depends on tsc_pkg, the channel interfaces in tsc_ifs.sv and the core itself.
module tb;
   import tsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 120;
   localparam int END_WAIT_CYCLES = 50000;
   localparam int RX_HOLD_CYCLES = 1000;
   localparam int PRINT_CAP = 200;

   localparam longint Z_MAX = 64'sd2147483647;
   localparam longint Z_MIN = -64'sd2147483648;
   localparam longint QUOT_CAP = longint'(1) << 40;
   localparam longint HALF_LSB = longint'(1) << (FRAC_BITS_DEF - 1);
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;
   localparam logic signed [WORD_W-1:0] Q_ONE = 32'sd65536;

   typedef struct packed {
      logic [SUM_W-1:0] upper_sum;
      logic [SUM_W-1:0] lower_sum;
      logic upper_alarm;
      logic lower_alarm;
      logic [WORD_W-1:0] sample_count;
      logic status;
   } cusum_result_type;

   logic clock = 1'b0;
   logic reset;

   tsc_req_if req_bus();
   tsc_rsp_if rsp_bus();
   tsc_csr_if csr_bus();

   two_sided_cusum_detector_core u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // predicted detector state and register copy
   tsc_cfg_type cfg_mirror = '{MEAN_REF_RST, PROCESS_SIGMA_RST, DECISION_LIMIT_RST,
      SHIFT_TO_DETECT_RST};
   logic [SUM_W-1:0] up_sum = '0;
   logic [SUM_W-1:0] lo_sum = '0;
   logic up_alarm = 1'b0;
   logic lo_alarm = 1'b0;
   logic [WORD_W-1:0] samples_seen = '0;

   cusum_result_type cusum_expected[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic rx_hold = 1'b0;
   event rx_hold_ev;

   int mismatch_count = 0;
   int n_checked = 0;
   int n_samples = 0;
   int n_clears = 0;
   int n_sigma_errors = 0;
   int n_upper_alarms = 0;
   int n_lower_alarms = 0;
   int n_reg_writes = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // num * 2^FRAC / den, truncated toward zero, magnitude capped
   function automatic longint scaled_quotient(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag << FRAC_BITS_DEF) / den;
      if (q > QUOT_CAP) q = QUOT_CAP;
      return (num < 0) ? -q : q;
   endfunction

   function automatic logic [SUM_W-1:0] clamp_sum(longint v);
      if (v < 0) return '0;
      if (v > longint'(SUM_MAX)) return SUM_MAX;
      return SUM_W'(v);
   endfunction

   function automatic logic signed [WORD_W-1:0] clip_word(longint v);
      if (v > Z_MAX) return WORD_MAX;
      if (v < Z_MIN) return WORD_MIN;
      return WORD_W'(v);
   endfunction

   // advance the CUSUM state by one request word and return the response it gives
   function automatic cusum_result_type advance_cusum(logic kind,
                                                      logic signed [WORD_W-1:0] x);
      cusum_result_type r;
      longint z, k, sigma;
      r.status = STATUS_OK;
      sigma = longint'(cfg_mirror.process_sigma);
      if (kind == REQ_CLEAR) begin
         up_sum = '0;
         lo_sum = '0;
         up_alarm = 1'b0;
         lo_alarm = 1'b0;
         samples_seen = '0;
      end else if (sigma == 0) begin
         r.status = STATUS_SIGMA_ZERO;
      end else begin
         z = scaled_quotient(longint'(x) - longint'($signed(cfg_mirror.mean_ref)), sigma);
         k = scaled_quotient(longint'($signed(cfg_mirror.shift_to_detect)), 2 * sigma);
         if (z > Z_MAX) z = Z_MAX;
         if (z < Z_MIN) z = Z_MIN;
         if (k > Z_MAX) k = Z_MAX;
         // a reference value below one LSB falls back to one half
         if (k < 1) k = HALF_LSB;
         up_sum = clamp_sum(longint'(up_sum) + z - k);
         lo_sum = clamp_sum(longint'(lo_sum) - z - k);
         up_alarm = (up_sum > cfg_mirror.decision_limit);
         lo_alarm = (lo_sum > cfg_mirror.decision_limit);
         if (samples_seen != COUNT_MAX) samples_seen++;
      end
      r.upper_sum = up_sum;
      r.lower_sum = lo_sum;
      r.upper_alarm = up_alarm;
      r.lower_alarm = lo_alarm;
      r.sample_count = samples_seen;
      return r;
   endfunction

   // sample around the target with a given mean shift; some full-range noise
   function automatic logic signed [WORD_W-1:0] pick_sample(longint drift);
      longint unsigned raw;
      longint spread, offset;
      int unsigned mode;
      mode = $urandom_range(0, 19);
      if (mode == 0) return $urandom;
      if (mode == 1) return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
      spread = 3 * longint'(cfg_mirror.process_sigma) + 1;
      raw = {$urandom, $urandom};
      offset = longint'(raw % longint'(2 * spread + 1)) - spread;
      return clip_word(longint'($signed(cfg_mirror.mean_ref)) + drift + offset);
   endfunction

   // offer one request word, idling at random first; valid stays up after acceptance
   task automatic send_word(logic kind, logic signed [WORD_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.sample <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      cusum_expected.push_back(advance_cusum(kind, value));
      if (kind == REQ_CLEAR) n_clears++;
      else n_samples++;
   endtask

   // drop valid and hold until every response word has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (cusum_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(tsc_reg_type idx, logic [WORD_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.addr <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         REG_MEAN_REF: cfg_mirror.mean_ref = data;
         REG_PROCESS_SIGMA: cfg_mirror.process_sigma = data[SUM_W-1:0];
         REG_DECISION_LIMIT: cfg_mirror.decision_limit = data[SUM_W-1:0];
         REG_SHIFT_TO_DETECT: cfg_mirror.shift_to_detect = data;
         default: ;
      endcase
      n_reg_writes++;
   endtask

   // write all four registers while the core is idle
   task automatic load_config(logic [WORD_W-1:0] mean_w, logic [WORD_W-1:0] sigma_w,
                              logic [WORD_W-1:0] limit_w, logic [WORD_W-1:0] shift_w);
      wait_drained();
      csr_write(REG_MEAN_REF, mean_w);
      csr_write(REG_PROCESS_SIGMA, sigma_w);
      csr_write(REG_DECISION_LIMIT, limit_w);
      csr_write(REG_SHIFT_TO_DETECT, shift_w);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_default_config();
      load_config(MEAN_REF_RST, WORD_W'(PROCESS_SIGMA_RST), WORD_W'(DECISION_LIMIT_RST),
         SHIFT_TO_DETECT_RST);
   endtask

   task automatic load_random_config();
      logic [WORD_W-1:0] mean_w, sigma_w, limit_w, shift_w;
      longint sig;
      case ($urandom_range(0, 19))
         0: sigma_w = '0;
         1, 2: sigma_w = $urandom;
         3, 4: sigma_w = $urandom_range(1, 64);
         default: sigma_w = $urandom_range(1 << 10, 1 << 22);
      endcase
      sig = longint'(sigma_w[SUM_W-1:0]);
      mean_w = ($urandom_range(0, 4) == 0) ? $urandom :
         WORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      limit_w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 32'h7fffffff) :
         $urandom_range(1 << 16, 1 << 20);
      shift_w = ($urandom_range(0, 4) == 0) ? $urandom :
         clip_word(sig * (int'($urandom_range(0, 6)) - 1));
      load_config(mean_w, sigma_w, limit_w, shift_w);
   endtask

   // reset values: equality with the limit, extremes of the sample, clear
   task automatic test_default_config();
      send_word(REQ_SAMPLE, 32'sd0);
      send_word(REQ_SAMPLE, 3 * Q_ONE);
      send_word(REQ_SAMPLE, 3 * Q_ONE);
      send_word(REQ_SAMPLE, Q_ONE);
      send_word(REQ_SAMPLE, WORD_MIN);
      send_word(REQ_SAMPLE, WORD_MAX);
      send_word(REQ_SAMPLE, WORD_MAX);
      send_word(REQ_CLEAR, WORD_MAX);
   endtask

   // saturation of z and k, non-positive shift, register extremes, masked sigma
   task automatic test_config_extremes();
      load_config(WORD_MAX, 32'd1, 32'd1, WORD_MAX);
      send_word(REQ_SAMPLE, WORD_MIN);
      send_word(REQ_SAMPLE, 32'sd0);
      load_config(WORD_MIN, 32'd1, 32'd1, WORD_MIN);
      send_word(REQ_SAMPLE, WORD_MAX);
      send_word(REQ_SAMPLE, 32'sd0);
      load_config(WORD_MIN, 32'd1, 32'h7fffffff, 32'd0);
      send_word(REQ_SAMPLE, WORD_MAX);
      load_config(32'd0, 32'hffffffff, WORD_W'(DECISION_LIMIT_RST), Q_ONE);
      send_word(REQ_SAMPLE, WORD_MIN);
      send_word(REQ_SAMPLE, WORD_MAX);
   endtask

   // zero sigma: error status with state held, clear still succeeds
   task automatic test_sigma_zero();
      load_config(32'd0, 32'd0, WORD_W'(DECISION_LIMIT_RST), Q_ONE);
      send_word(REQ_SAMPLE, Q_ONE);
      send_word(REQ_CLEAR, 32'sd0);
      send_word(REQ_SAMPLE, -Q_ONE);
      load_default_config();
      send_word(REQ_SAMPLE, 2 * Q_ONE);
   endtask

   // bursts of shifted sample runs under fresh settings, with clears mixed in
   task automatic test_random_traffic(int tx_idle, int rx_idle, int n_items);
      int sent, burst;
      longint drift;
      send_idle_pct = tx_idle;
      recv_idle_pct = rx_idle;
      sent = 0;
      while (sent < n_items) begin
         load_random_config();
         burst = $urandom_range(25, 70);
         drift = 0;
         repeat (burst) begin
            case ($urandom_range(0, 29))
               0: send_word(REQ_CLEAR, $urandom);
               1, 2: begin
                  drift = longint'(cfg_mirror.process_sigma) *
                     (int'($urandom_range(0, 8)) - 4) / 2;
                  send_word(REQ_SAMPLE, pick_sample(drift));
               end
               default: send_word(REQ_SAMPLE, pick_sample(drift));
            endcase
            sent++;
         end
      end
   endtask

   // stall the response side long enough for the core to back up its input
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_default_config();
      -> rx_hold_ev;
      repeat (14) send_word(REQ_SAMPLE, pick_sample(2 * longint'(cfg_mirror.process_sigma)));
      wait_drained();
   endtask

   // sums must carry over a pause in which the core fully drains
   task automatic test_pause_until_drained();
      send_idle_pct = 17;
      recv_idle_pct = 17;
      repeat (10) send_word(REQ_SAMPLE, pick_sample(-longint'(cfg_mirror.process_sigma)));
      wait_drained();
      repeat (10) send_word(REQ_SAMPLE, pick_sample(longint'(cfg_mirror.process_sigma)));
   endtask

   // response side: random ready, forced low during a hold-off
   always @(posedge clock) begin
      if (reset || rx_hold) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // hold off the response side for a fixed stretch of cycles
   always @(rx_hold_ev) begin
      rx_hold <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // compare each accepted response word with the oldest prediction
   always @(posedge clock) begin
      cusum_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (cusum_expected.size() == 0) begin
            report_mismatch("response word with nothing expected", rsp_bus.sample_count, 0);
         end else begin
            want = cusum_expected.pop_front();
            n_checked++;
            if (rsp_bus.upper_sum !== want.upper_sum)
               report_mismatch("upper_sum", rsp_bus.upper_sum, want.upper_sum);
            if (rsp_bus.lower_sum !== want.lower_sum)
               report_mismatch("lower_sum", rsp_bus.lower_sum, want.lower_sum);
            if (rsp_bus.upper_alarm !== want.upper_alarm)
               report_mismatch("upper_alarm", rsp_bus.upper_alarm, want.upper_alarm);
            if (rsp_bus.lower_alarm !== want.lower_alarm)
               report_mismatch("lower_alarm", rsp_bus.lower_alarm, want.lower_alarm);
            if (rsp_bus.sample_count !== want.sample_count)
               report_mismatch("sample_count", rsp_bus.sample_count, want.sample_count);
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (want.status == STATUS_SIGMA_ZERO) n_sigma_errors++;
            if (want.upper_alarm) n_upper_alarms++;
            if (want.lower_alarm) n_lower_alarms++;
         end
      end
   end

   // watchdog
   initial begin
      longint cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles, %0d words still expected", cycles,
         cusum_expected.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int waited;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_SAMPLE;
      req_bus.sample = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.addr = REG_MEAN_REF;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_config();
      test_config_extremes();
      test_sigma_zero();
      test_random_traffic(17, 51, 580);
      test_random_traffic(51, 17, 580);
      test_random_traffic(0, 0, 580);
      test_output_backpressure();
      test_pause_until_drained();

      // drain and let the pipeline run dry
      req_bus.valid <= 1'b0;
      waited = 0;
      while (cusum_expected.size() != 0 && waited < END_WAIT_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (cusum_expected.size() != 0)
         report_mismatch("responses never delivered", 0, cusum_expected.size());

      $display("Covered %0d samples, %0d clears, %0d sigma-zero errors, %0d register writes",
         n_samples, n_clears, n_sigma_errors, n_reg_writes);
      $display("Checked %0d responses; %0d with upper alarm, %0d with lower alarm",
         n_checked, n_upper_alarms, n_lower_alarms);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
